// ===== rtl/tts_pkg.sv =====
// shared constants and types of the rgba8 texture tile swizzle
`default_nettype none
package tts_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int TILE_SIDE   = 4;
	localparam int STORE_DEPTH = TILE_SIDE * MAX_WIDTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int SUB_W       = $clog2(TILE_SIDE);
	localparam int TIDX_W      = COL_W - SUB_W;
	localparam int MAX_TILES   = MAX_WIDTH / TILE_SIDE;
	localparam int MAX_STRIPS  = 256;
	localparam int STRIP_W     = $clog2(MAX_STRIPS);
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CHAN_W      = 8;
	localparam int PIX_W       = 4 * CHAN_W;
	localparam int HALF_W      = PIX_W / 2;
	localparam int TEXELS      = TILE_SIDE * TILE_SIDE;
	localparam int TILE_WORDS  = 2 * TEXELS;
	localparam int WCNT_W      = $clog2(TILE_WORDS);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int OF_DEPTH    = 4;
	localparam int OF_PTR_W    = $clog2(OF_DEPTH);
	localparam int OF_CNT_W    = OF_PTR_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_TILES  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN_TILES = CFG_IDX_W'(1);

	localparam logic [SUB_W-1:0] LAST_SUB = SUB_W'(TILE_SIDE - 1);

	typedef struct packed {
		logic [TIDX_W-1:0] idx;
		logic              last_img;
	} tts_tile_t;

	typedef struct packed {
		logic [QDEPTH-1:0]            vld;
		tts_tile_t [QDEPTH-1:0]       ent;
	} tts_qview_t;

	typedef struct packed {
		logic      busy;
		tts_tile_t cur;
	} tts_bview_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  data;
	} tts_wr_t;

	typedef struct packed {
		logic [HALF_W-1:0] texel_pair;
		logic              last_of_tile;
		logic              end_of_image;
	} tts_word_t;

endpackage
`default_nettype wire

// ===== rtl/tts_if.sv =====
// pixel and output word channel interfaces
`default_nettype none
interface tts_pixel_if;
	import tts_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface tts_word_if;
	import tts_pkg::*;
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] texel_pair;
	logic              last_of_tile;
	logic              end_of_image;

	modport source (output valid, texel_pair, last_of_tile, end_of_image, input ready);
	modport sink (input valid, texel_pair, last_of_tile, end_of_image, output ready);
endinterface
`default_nettype wire

// ===== rtl/tts_line_store.sv =====
// four-row line store, one write and one registered read port
`default_nettype none
module tts_line_store
	import tts_pkg::*;
(
	input  wire logic              clk,
	input  wire tts_wr_t           wr,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [PIX_W-1:0]  rd_data
);

	logic [PIX_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tts_front.sv =====
// raster counters, config registers, store writes and tile classification
`default_nettype none
module tts_front
	import tts_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	tts_pixel_if.sink                 pixel,
	input  wire tts_qview_t           qview,
	input  wire tts_bview_t           bview,
	output tts_wr_t                   wr,
	output logic                      push,
	output tts_tile_t                 push_tile
);

	logic [CFG_W-1:0]   width_q;
	logic [CFG_W-1:0]   height_q;
	logic [COL_W-1:0]   col_q;
	logic [SUB_W-1:0]   row_q;
	logic [STRIP_W-1:0] strip_q;

	logic [TIDX_W-1:0]  wlast;
	logic [STRIP_W-1:0] hlast;
	logic [TIDX_W-1:0]  col_tile;
	logic               row_end;
	logic               fire;
	logic               conflict;
	logic               q_full;
	logic               accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WIDTH_IN_TILES:  width_q  <= cfg_wdata;
				REG_HEIGHT_IN_TILES: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			wlast = '0;
		end else if (width_q >= CFG_W'(MAX_TILES)) begin
			wlast = TIDX_W'(MAX_TILES - 1);
		end else begin
			wlast = TIDX_W'(width_q - CFG_W'(1));
		end
		if (height_q == '0) begin
			hlast = '0;
		end else if (height_q >= CFG_W'(MAX_STRIPS)) begin
			hlast = STRIP_W'(MAX_STRIPS - 1);
		end else begin
			hlast = STRIP_W'(height_q - CFG_W'(1));
		end
	end

	assign col_tile = col_q[COL_W-1:SUB_W];
	assign row_end  = (col_tile > wlast) || (col_tile == wlast && col_q[SUB_W-1:0] == LAST_SUB);
	assign fire     = row_q == LAST_SUB && col_q[SUB_W-1:0] == LAST_SUB && col_tile <= wlast;
	assign q_full   = &qview.vld;

	// rows above the last one must not overwrite a tile still waiting to be read
	always_comb begin
		conflict = bview.busy && bview.cur.idx == col_tile;
		for (int i = 0; i < QDEPTH; i++) begin
			if (qview.vld[i] && qview.ent[i].idx == col_tile) begin
				conflict = 1'b1;
			end
		end
		if (row_q == LAST_SUB) begin
			conflict = 1'b0;
		end
	end

	assign pixel.ready = !conflict && !(fire && q_full);
	assign accept      = pixel.valid && pixel.ready;

	assign wr.we   = accept;
	assign wr.addr = {row_q, col_q};
	assign wr.data = {pixel.alpha, pixel.red, pixel.green, pixel.blue};

	assign push               = accept && fire;
	assign push_tile.idx      = col_tile;
	assign push_tile.last_img = col_tile == wlast && strip_q >= hlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			strip_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				if (row_q == LAST_SUB) begin
					row_q   <= '0;
					strip_q <= (strip_q >= hlast) ? '0 : strip_q + STRIP_W'(1);
				end else begin
					row_q <= row_q + SUB_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tts_tile_queue.sv =====
// short queue of completed tiles between front and back
`default_nettype none
module tts_tile_queue
	import tts_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire tts_tile_t push_tile,
	input  wire logic      pop,
	output logic           head_vld,
	output tts_tile_t      head,
	output tts_qview_t     qview
);

	tts_tile_t [QDEPTH-1:0] ent_q;
	logic [QDEPTH-1:0]      vld_q;
	logic [QPTR_W-1:0]      wr_ptr_q;
	logic [QPTR_W-1:0]      rd_ptr_q;

	assign head_vld  = vld_q[rd_ptr_q];
	assign head      = ent_q[rd_ptr_q];
	assign qview.vld = vld_q;
	assign qview.ent = ent_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_tile;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (pop) begin
				vld_q[rd_ptr_q] <= 1'b0;
				rd_ptr_q        <= rd_ptr_q + QPTR_W'(1);
			end
			if (push) begin
				vld_q[wr_ptr_q] <= 1'b1;
				wr_ptr_q        <= wr_ptr_q + QPTR_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tts_back.sv =====
// tile read sequencer and output word buffer
`default_nettype none
module tts_back
	import tts_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_vld,
	input  wire tts_tile_t         head,
	output logic                   pop,
	output logic                   rd_en,
	output logic      [ADDR_W-1:0] rd_addr,
	input  wire logic [PIX_W-1:0]  rd_data,
	output tts_bview_t             bview,
	tts_word_if.source             tile_word
);

	logic               busy_q;
	tts_tile_t          cur_q;
	logic [WCNT_W-1:0]  word_q;
	logic               rd_vld_s1;
	logic               half_s1;
	logic               lt_s1;
	logic               eoi_s1;

	tts_word_t [OF_DEPTH-1:0] of_q;
	logic [OF_PTR_W-1:0] of_wr_q;
	logic [OF_PTR_W-1:0] of_rd_q;
	logic [OF_CNT_W-1:0] of_cnt_q;

	logic      space;
	logic      issue;
	logic      last_word;
	logic      out_pop;
	tts_word_t push_word;

	assign space     = ({1'b0, of_cnt_q} + (OF_CNT_W + 1)'(rd_vld_s1)) < (OF_CNT_W + 1)'(OF_DEPTH);
	assign issue     = busy_q && space;
	assign last_word = word_q == WCNT_W'(TILE_WORDS - 1);
	assign pop       = head_vld && (!busy_q || (issue && last_word));

	// word bits: texel index low, color half on top
	assign rd_en   = issue;
	assign rd_addr = {word_q[SUB_W+SUB_W-1:SUB_W], cur_q.idx, word_q[SUB_W-1:0]};

	assign bview.busy = busy_q;
	assign bview.cur  = cur_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		half_s1 <= word_q[WCNT_W-1];
		lt_s1   <= last_word;
		eoi_s1  <= last_word && cur_q.last_img;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			word_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (pop) begin
				busy_q <= 1'b1;
				word_q <= '0;
			end else if (issue) begin
				word_q <= word_q + WCNT_W'(1);
				if (last_word) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign push_word.texel_pair   = half_s1 ? rd_data[HALF_W-1:0] : rd_data[PIX_W-1:HALF_W];
	assign push_word.last_of_tile = lt_s1;
	assign push_word.end_of_image = eoi_s1;

	assign out_pop                = tile_word.valid && tile_word.ready;
	assign tile_word.valid        = of_cnt_q != '0;
	assign tile_word.texel_pair   = of_q[of_rd_q].texel_pair;
	assign tile_word.last_of_tile = of_q[of_rd_q].last_of_tile;
	assign tile_word.end_of_image = of_q[of_rd_q].end_of_image;

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			of_q[of_wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			of_wr_q  <= '0;
			of_rd_q  <= '0;
			of_cnt_q <= '0;
		end else begin
			if (rd_vld_s1) begin
				of_wr_q <= of_wr_q + OF_PTR_W'(1);
			end
			if (out_pop) begin
				of_rd_q <= of_rd_q + OF_PTR_W'(1);
			end
			priority if (rd_vld_s1 && !out_pop) begin
				of_cnt_q <= of_cnt_q + OF_CNT_W'(1);
			end else if (!rd_vld_s1 && out_pop) begin
				of_cnt_q <= of_cnt_q - OF_CNT_W'(1);
			end else begin
				of_cnt_q <= of_cnt_q;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rgba8_texture_tile_swizzle.sv =====
// rgba8 raster to 4x4 tiled ar/gb texture word converter, top level
// a pixel is taken in one cycle; the one completing a tile starts a burst of 32 words
// first word passes queue, tile register, store read register and output buffer,
// then one word per cycle while ready; the store's single read port sets the pace
// rows 0..2 stall while they would overwrite a tile still queued or being read
// arst_n clears counters, queue and buffers and sets both size registers to 1
`default_nettype none
module rgba8_texture_tile_swizzle
	import tts_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	tts_pixel_if.sink                 pixel,
	tts_word_if.source                tile_word
);

	tts_wr_t          wr;
	logic             push;
	tts_tile_t        push_tile;
	logic             pop;
	logic             head_vld;
	tts_tile_t        head;
	tts_qview_t       qview;
	tts_bview_t       bview;
	logic             rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [PIX_W-1:0] rd_data;

	tts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel),
		.qview     (qview),
		.bview     (bview),
		.wr        (wr),
		.push      (push),
		.push_tile (push_tile)
	);

	tts_tile_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tile (push_tile),
		.pop       (pop),
		.head_vld  (head_vld),
		.head      (head),
		.qview     (qview)
	);

	tts_line_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_vld  (head_vld),
		.head      (head),
		.pop       (pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.bview     (bview),
		.tile_word (tile_word)
	);

endmodule
`default_nettype wire

// ===== rtl/tts_checker.sv =====
// port-level checks of the tile swizzle output stream, bound to the top level
`default_nettype none
module tts_checker
	import tts_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              word_valid,
	input wire logic              word_ready,
	input wire logic [HALF_W-1:0] texel_pair,
	input wire logic              last_of_tile,
	input wire logic              end_of_image
);

	logic [WCNT_W-1:0] seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (word_valid && word_ready) begin
			seen_q <= seen_q + WCNT_W'(1);
		end
	end

	a_eoi_on_tile_end: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && end_of_image |-> last_of_tile)
		else $error("end of image flagged off a tile end");

	a_tile_len: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_ready |-> last_of_tile == (seen_q == WCNT_W'(TILE_WORDS - 1)))
		else $error("tile end flag not on every 32nd item");

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |=> word_valid && $stable(texel_pair)
			&& $stable(last_of_tile) && $stable(end_of_image))
		else $error("stalled output item changed");

endmodule

bind rgba8_texture_tile_swizzle tts_checker u_tts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.word_valid   (tile_word.valid),
	.word_ready   (tile_word.ready),
	.texel_pair   (tile_word.texel_pair),
	.last_of_tile (tile_word.last_of_tile),
	.end_of_image (tile_word.end_of_image)
);
`default_nettype wire

// ===== dv/rgba8_texture_tile_swizzle_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the rgba8 tile swizzle: random-paced pixels in, tile words checked in order
module rgba8_texture_tile_swizzle_tb;
	import tts_pkg::*;

	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS   = 60;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);

	typedef struct packed {
		logic [CHAN_W-1:0] alpha;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgba_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	tts_pixel_if pixel_ch ();
	tts_word_if  word_ch ();

	rgba8_texture_tile_swizzle u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel_ch),
		.tile_word (word_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the block: sizes, line store and raster position
	logic [CFG_W-1:0] width_tiles = CFG_W'(1);
	logic [CFG_W-1:0] height_tiles = CFG_W'(1);
	logic [PIX_W-1:0] line_rows [STORE_DEPTH];
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;
	int unsigned      strip_pos = 0;

	rgba_t       pending_pixels[$];
	tts_word_t   tile_words_due[$];
	tts_word_t   due_word;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_hold;
	int unsigned stall_hold;
	logic        steady;

	function automatic int unsigned image_width_px();
		int unsigned w;
		w = width_tiles;
		if (w < 1) w = 1;
		if (w > MAX_TILES) w = MAX_TILES;
		return w * TILE_SIDE;
	endfunction

	function automatic int unsigned image_strips();
		int unsigned h;
		h = height_tiles;
		if (h < 1) h = 1;
		if (h > MAX_STRIPS) h = MAX_STRIPS;
		return h;
	endfunction

	function automatic void advance_position(inout int unsigned col, inout int unsigned row,
		inout int unsigned strip);
		if (col + 1 >= image_width_px()) begin
			col = 0;
			if (row == TILE_SIDE - 1) begin
				row = 0;
				strip = (strip + 1 >= image_strips()) ? 0 : (strip + 1) % MAX_STRIPS;
			end else begin
				row = row + 1;
			end
		end else begin
			col = col + 1;
		end
	endfunction

	// store one pixel and queue the 32 words of the tile it completes, if any
	function automatic void absorb_pixel(input rgba_t px);
		int unsigned      wpx;
		int unsigned      col;
		int unsigned      x0;
		int unsigned      half;
		int unsigned      k;
		logic [PIX_W-1:0] texel;
		logic             last_img;
		tts_word_t        w;
		wpx = image_width_px();
		col = col_pos % MAX_WIDTH;
		line_rows[row_pos * MAX_WIDTH + col] = px;
		if (row_pos == TILE_SIDE - 1 && col % TILE_SIDE == TILE_SIDE - 1 && col < wpx) begin
			x0 = col - (TILE_SIDE - 1);
			last_img = (col + 1 == wpx) && (strip_pos + 1 >= image_strips());
			for (half = 0; half < 2; half++) begin
				for (k = 0; k < TEXELS; k++) begin
					texel = line_rows[(k / TILE_SIDE) * MAX_WIDTH + x0 + k % TILE_SIDE];
					w.texel_pair = (half == 0) ? texel[PIX_W-1:HALF_W] : texel[HALF_W-1:0];
					w.last_of_tile = (half == 1) && (k == TEXELS - 1);
					w.end_of_image = w.last_of_tile && last_img;
					tile_words_due.push_back(w);
				end
			end
		end
		col_pos = col;
		advance_position(col_pos, row_pos, strip_pos);
	endfunction

	function automatic int unsigned pixels_to_image_end();
		int unsigned c;
		int unsigned r;
		int unsigned s;
		int unsigned n;
		c = col_pos % MAX_WIDTH;
		r = row_pos;
		s = strip_pos;
		n = 0;
		do begin
			advance_position(c, r, s);
			n++;
		end while (c != 0 || r != 0 || s != 0);
		return n;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 65) return 0;
		if (roll < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic queue_random_pixels(input int unsigned count);
		repeat (count) pending_pixels.push_back(rgba_t'($urandom));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_WIDTH_IN_TILES: width_tiles = value;
			REG_HEIGHT_IN_TILES: height_tiles = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_pixels.size() != 0 || pixel_ch.valid || tile_words_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver: pixel channel and word-side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_ch.valid <= 1'b0;
			pixel_ch.red <= '0;
			pixel_ch.green <= '0;
			pixel_ch.blue <= '0;
			pixel_ch.alpha <= '0;
			word_ch.ready <= 1'b0;
			send_hold <= 0;
			stall_hold <= 0;
			steady <= 1'b0;
		end else begin
			if ($urandom_range(255, 0) == 0) steady <= !steady;
			if (!pixel_ch.valid || pixel_ch.ready) begin
				if (send_hold != 0 && !steady) begin
					pixel_ch.valid <= 1'b0;
					send_hold <= send_hold - 1;
				end else if (pending_pixels.size() != 0) begin
					pixel_ch.red <= pending_pixels[0].red;
					pixel_ch.green <= pending_pixels[0].green;
					pixel_ch.blue <= pending_pixels[0].blue;
					pixel_ch.alpha <= pending_pixels[0].alpha;
					void'(pending_pixels.pop_front());
					pixel_ch.valid <= 1'b1;
					send_hold <= idle_len();
				end else begin
					pixel_ch.valid <= 1'b0;
				end
			end
			if (stall_hold != 0 && !steady) begin
				word_ch.ready <= 1'b0;
				stall_hold <= stall_hold - 1;
			end else begin
				word_ch.ready <= 1'b1;
				stall_hold <= idle_len();
			end
		end
	end

	// monitor: predict on each accepted pixel, check each accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_ch.valid && pixel_ch.ready)
				absorb_pixel({pixel_ch.alpha, pixel_ch.red, pixel_ch.green, pixel_ch.blue});
			if (word_ch.valid && word_ch.ready) begin
				if (tile_words_due.size() == 0) begin
					$error("tile word %h arrived with none due", word_ch.texel_pair);
					error_count++;
				end else begin
					due_word = tile_words_due.pop_front();
					if (word_ch.texel_pair !== due_word.texel_pair) begin
						$error("texel_pair: expected %h, got %h", due_word.texel_pair,
							word_ch.texel_pair);
						error_count++;
					end
					if (word_ch.last_of_tile !== due_word.last_of_tile) begin
						$error("last_of_tile: expected %b, got %b", due_word.last_of_tile,
							word_ch.last_of_tile);
						error_count++;
					end
					if (word_ch.end_of_image !== due_word.end_of_image) begin
						$error("end_of_image: expected %b, got %b", due_word.end_of_image,
							word_ch.end_of_image);
						error_count++;
					end
				end
			end
			if ((pixel_ch.valid && pixel_ch.ready) || (word_ch.valid && word_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		rgba_t       px;
		int unsigned i;
		int unsigned count;
		int unsigned random_sent;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		random_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset sizes: one tile with channel extremes and walking bits
		for (i = 0; i < TEXELS; i++) begin
			if (i == 0) begin
				px = '0;
			end else if (i == 1) begin
				px = '1;
			end else begin
				px.red = CHAN_W'(1) << (i % CHAN_W);
				px.green = ~px.red;
				px.blue = CHAN_W'(8'h80) >> (i % CHAN_W);
				px.alpha = CHAN_W'(i * 17);
			end
			pending_pixels.push_back(px);
		end
		wait_drained();

		// zero sizes act as one; unmapped indexes are ignored
		write_reg(REG_WIDTH_IN_TILES, '0);
		write_reg(REG_HEIGHT_IN_TILES, '0);
		write_reg(REG_UNMAPPED_LO, '1);
		write_reg(REG_UNMAPPED_HI, CFG_W'(9'h0aa));
		queue_random_pixels(TEXELS);
		wait_drained();

		// narrow the width mid-row on the last row of a strip
		write_reg(REG_WIDTH_IN_TILES, CFG_W'(3));
		write_reg(REG_HEIGHT_IN_TILES, CFG_W'(1));
		queue_random_pixels(3 * 3 * TILE_SIDE + 7);
		wait_drained();
		write_reg(REG_WIDTH_IN_TILES, CFG_W'(1));
		queue_random_pixels(pixels_to_image_end());

		// random small images, some cut short before a resize
		while (random_sent < RANDOM_ITEMS) begin
			wait_drained();
			write_reg(REG_WIDTH_IN_TILES,
				($urandom_range(9, 0) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(3, 1)));
			if ($urandom_range(2, 0) == 0)
				write_reg(REG_HEIGHT_IN_TILES, CFG_W'($urandom_range(2, 0)));
			if ($urandom_range(7, 0) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
					CFG_W'($urandom));
			count = pixels_to_image_end();
			if ($urandom_range(4, 0) == 0) count = $urandom_range(count, 1);
			queue_random_pixels(count);
			random_sent += count;
		end
		wait_drained();

		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== rgba8_texture_tile_swizzle.f =====
rtl/tts_pkg.sv
rtl/tts_if.sv
rtl/tts_line_store.sv
rtl/tts_front.sv
rtl/tts_tile_queue.sv
rtl/tts_back.sv
rtl/rgba8_texture_tile_swizzle.sv
rtl/tts_checker.sv
dv/rgba8_texture_tile_swizzle_tb.sv
